FILE: design/rpq_pkg.sv
// rpq_pkg: shared types, sizes and codes for the ready priority queue.
// Used by every module of the block but rpq_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rpq_pkg;

	localparam int CAPACITY      = 32;
	localparam int PRIORITY_BITS = 8;

	localparam int ID_W          = 5;
	localparam int PRIO_REQ_W    = 8;
	localparam int COUNT_OUT_W   = 6;
	localparam int CNT_W         = $clog2(CAPACITY + 1);
	localparam int IDX_W         = $clog2(CAPACITY);
	localparam int PRIO_EXT_W    = (PRIORITY_BITS > PRIO_REQ_W) ? PRIORITY_BITS : PRIO_REQ_W;

	// command codes
	localparam logic [1:0] CMD_ENQUEUE = 2'd0;
	localparam logic [1:0] CMD_POP     = 2'd1;
	localparam logic [1:0] CMD_REMOVE  = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [1:0]            command;
		logic [ID_W-1:0]       task_id;
		logic [PRIO_REQ_W-1:0] priority_req;
	} cmd_word_t;

	typedef struct packed {
		logic [ID_W-1:0]        result_id;
		logic [1:0]             status;
		logic [COUNT_OUT_W-1:0] entry_count;
	} rsp_word_t;

	typedef struct packed {
		logic [ID_W-1:0]          id;
		logic [PRIORITY_BITS-1:0] prio;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [1:0] {
		RD_IDX,
		RD_IDX_M1,
		RD_IDX_M2
	} rd_sel_t;

	typedef enum logic {
		WA_IDX,
		WA_PREV_M1
	} wa_sel_t;

	typedef enum logic {
		WD_NEW,
		WD_RDATA
	} wd_sel_t;

	typedef enum logic [2:0] {
		RES_NONE,
		RES_OK_OP,
		RES_OK_RD,
		RES_FULL,
		RES_EMPTY,
		RES_NOT_FOUND
	} res_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic     capture;
		logic     idx_clr;
		logic     idx_inc;
		logic     idx_dec;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     wr_en;
		wa_sel_t  wa_sel;
		wd_sel_t  wd_sel;
		logic     set_found;
		logic     cnt_inc;
		logic     cnt_dec;
		logic     set_res;
		res_sel_t res_sel;
		logic     load_rsp;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic       cnt_zero;
		logic       cnt_full;
		logic       idx_zero;
		logic       idx_one;
		logic       prio_ge;
		logic       id_match;
		logic       found;
		logic       scan_last;
		logic [1:0] op_cmd;
	} dp_sts_t;

	// only the low PRIORITY_BITS of the request count
	function automatic logic [PRIORITY_BITS-1:0] to_prio(input logic [PRIO_REQ_W-1:0] p);
		logic [PRIO_EXT_W-1:0] ext;
		ext = PRIO_EXT_W'(p);
		return ext[PRIORITY_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: design/rpq_ram.sv
// rpq_ram: generic simple dual-port RAM, one write and one registered read port.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module rpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: design/rpq_dp.sv
// rpq_dp: datapath - entry RAM, count, walk index, operand and response registers.
// Depends on rpq_pkg and rpq_ram; driven by rpq_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module rpq_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rpq_pkg::cmd_word_t cmd_word,
	input  wire rpq_pkg::dp_cmd_t   ctl,
	output rpq_pkg::dp_sts_t        sts,
	output rpq_pkg::rsp_word_t      rsp_word
);

	rpq_pkg::cmd_word_t                 op_q;
	logic [rpq_pkg::PRIORITY_BITS-1:0]  op_prio_q;
	logic [rpq_pkg::CNT_W-1:0]          count_q;
	logic [rpq_pkg::CNT_W-1:0]          idx_q;
	logic                               found_q;
	logic [rpq_pkg::IDX_W-1:0]          rd_addr_s1;
	logic [rpq_pkg::ID_W-1:0]           res_id_q;
	logic [1:0]                         res_status_q;
	rpq_pkg::rsp_word_t                 rsp_q;

	logic [rpq_pkg::CNT_W-1:0]          rd_idx;
	logic [rpq_pkg::IDX_W-1:0]          rd_addr;
	logic [rpq_pkg::IDX_W-1:0]          wr_addr;
	rpq_pkg::entry_t                    wr_data;
	rpq_pkg::entry_t                    new_entry;
	rpq_pkg::entry_t                    rd_data;

	assign new_entry.id   = op_q.task_id;
	assign new_entry.prio = op_prio_q;

	always_comb begin
		case (ctl.rd_sel)
			rpq_pkg::RD_IDX:    rd_idx = idx_q;
			rpq_pkg::RD_IDX_M1: rd_idx = idx_q - rpq_pkg::CNT_W'(1);
			rpq_pkg::RD_IDX_M2: rd_idx = idx_q - rpq_pkg::CNT_W'(2);
			default:            rd_idx = idx_q;
		endcase
	end
	assign rd_addr = rd_idx[rpq_pkg::IDX_W-1:0];

	// remove shifts each later entry one place down
	assign wr_addr = (ctl.wa_sel == rpq_pkg::WA_PREV_M1) ?
		(rd_addr_s1 - rpq_pkg::IDX_W'(1)) : idx_q[rpq_pkg::IDX_W-1:0];
	assign wr_data = (ctl.wd_sel == rpq_pkg::WD_RDATA) ? rd_data : new_entry;

	rpq_ram #(
		.WIDTH (rpq_pkg::ENTRY_W),
		.DEPTH (rpq_pkg::CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (ctl.wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (ctl.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			found_q <= 1'b0;
		end else begin
			if (ctl.capture) begin
				idx_q   <= count_q;
				found_q <= 1'b0;
			end else if (ctl.idx_clr) begin
				idx_q <= '0;
			end else if (ctl.idx_inc) begin
				idx_q <= idx_q + rpq_pkg::CNT_W'(1);
			end else if (ctl.idx_dec) begin
				idx_q <= idx_q - rpq_pkg::CNT_W'(1);
			end
			if (ctl.set_found) begin
				found_q <= 1'b1;
			end
			if (ctl.cnt_inc) begin
				count_q <= count_q + rpq_pkg::CNT_W'(1);
			end else if (ctl.cnt_dec) begin
				count_q <= count_q - rpq_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			op_q      <= cmd_word;
			op_prio_q <= rpq_pkg::to_prio(cmd_word.priority_req);
		end
		if (ctl.rd_en) begin
			rd_addr_s1 <= rd_addr;
		end
		if (ctl.set_res) begin
			case (ctl.res_sel)
				rpq_pkg::RES_OK_OP: begin
					res_id_q     <= op_q.task_id;
					res_status_q <= rpq_pkg::ST_OK;
				end
				rpq_pkg::RES_OK_RD: begin
					res_id_q     <= rd_data.id;
					res_status_q <= rpq_pkg::ST_OK;
				end
				rpq_pkg::RES_FULL: begin
					res_id_q     <= '0;
					res_status_q <= rpq_pkg::ST_FULL;
				end
				rpq_pkg::RES_EMPTY: begin
					res_id_q     <= '0;
					res_status_q <= rpq_pkg::ST_EMPTY;
				end
				rpq_pkg::RES_NOT_FOUND: begin
					res_id_q     <= '0;
					res_status_q <= rpq_pkg::ST_NOT_FOUND;
				end
				default: begin
					res_id_q     <= '0;
					res_status_q <= rpq_pkg::ST_OK;
				end
			endcase
		end
		if (ctl.load_rsp) begin
			rsp_q.result_id   <= res_id_q;
			rsp_q.status      <= res_status_q;
			rsp_q.entry_count <= rpq_pkg::COUNT_OUT_W'(count_q);
		end
	end

	assign rsp_word = rsp_q;

	assign sts.cnt_zero  = (count_q == '0);
	assign sts.cnt_full  = (count_q == rpq_pkg::CNT_W'(rpq_pkg::CAPACITY));
	assign sts.idx_zero  = (idx_q == '0);
	assign sts.idx_one   = (idx_q == rpq_pkg::CNT_W'(1));
	assign sts.prio_ge   = (rd_data.prio >= op_prio_q);
	assign sts.id_match  = (rd_data.id == op_q.task_id);
	assign sts.found     = found_q;
	assign sts.scan_last = (idx_q == count_q);
	assign sts.op_cmd    = op_q.command;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rpq_pkg::CNT_W'(rpq_pkg::CAPACITY))
		else $error("entry count beyond capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == $past(count_q)) || (count_q == $past(count_q) + rpq_pkg::CNT_W'(1)) ||
		(count_q == $past(count_q) - rpq_pkg::CNT_W'(1)))
		else $error("entry count moved by more than one");

	a_shift_after_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.wr_en && ctl.wa_sel == rpq_pkg::WA_PREV_M1) |-> found_q)
		else $error("remove shift before the id was found");
`endif

endmodule

`default_nettype wire

FILE: design/rpq_ctrl.sv
// rpq_ctrl: controller state machine sequencing enqueue, pop and remove walks.
// Depends on rpq_pkg; commands rpq_dp and owns the handshake control.
`timescale 1ns / 1ps
`default_nettype none

module rpq_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_valid,
	output logic                  cmd_stall,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	input  wire rpq_pkg::dp_sts_t sts,
	output rpq_pkg::dp_cmd_t      ctl
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_ENQ_START,
		S_ENQ_SCAN,
		S_ENQ_PLACE,
		S_POP_START,
		S_POP_WAIT,
		S_REM_START,
		S_REM_RD,
		S_REM_SCAN,
		S_REM_END,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   rsp_valid_q;
	logic   rsp_free;

	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	always_comb begin
		ctl       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.capture = 1'b1;
					state_nxt   = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.op_cmd)
					rpq_pkg::CMD_ENQUEUE: state_nxt = S_ENQ_START;
					rpq_pkg::CMD_POP:     state_nxt = S_POP_START;
					rpq_pkg::CMD_REMOVE:  state_nxt = S_REM_START;
					default: begin
						ctl.set_res = 1'b1;
						ctl.res_sel = rpq_pkg::RES_NONE;
						state_nxt   = S_DONE;
					end
				endcase
			end
			S_ENQ_START: begin
				if (sts.cnt_full) begin
					ctl.set_res = 1'b1;
					ctl.res_sel = rpq_pkg::RES_FULL;
					state_nxt   = S_DONE;
				end else if (sts.idx_zero) begin
					state_nxt = S_ENQ_PLACE;
				end else begin
					ctl.rd_en  = 1'b1;
					ctl.rd_sel = rpq_pkg::RD_IDX_M1;
					state_nxt  = S_ENQ_SCAN;
				end
			end
			S_ENQ_SCAN: begin
				// read data is the entry just below the hole
				if (sts.prio_ge) begin
					ctl.wr_en   = 1'b1;
					ctl.wa_sel  = rpq_pkg::WA_IDX;
					ctl.wd_sel  = rpq_pkg::WD_RDATA;
					ctl.idx_dec = 1'b1;
					if (sts.idx_one) begin
						state_nxt = S_ENQ_PLACE;
					end else begin
						ctl.rd_en  = 1'b1;
						ctl.rd_sel = rpq_pkg::RD_IDX_M2;
					end
				end else begin
					state_nxt = S_ENQ_PLACE;
				end
			end
			S_ENQ_PLACE: begin
				ctl.wr_en   = 1'b1;
				ctl.wa_sel  = rpq_pkg::WA_IDX;
				ctl.wd_sel  = rpq_pkg::WD_NEW;
				ctl.cnt_inc = 1'b1;
				ctl.set_res = 1'b1;
				ctl.res_sel = rpq_pkg::RES_OK_OP;
				state_nxt   = S_DONE;
			end
			S_POP_START: begin
				if (sts.cnt_zero) begin
					ctl.set_res = 1'b1;
					ctl.res_sel = rpq_pkg::RES_EMPTY;
					state_nxt   = S_DONE;
				end else begin
					ctl.rd_en   = 1'b1;
					ctl.rd_sel  = rpq_pkg::RD_IDX_M1;
					ctl.cnt_dec = 1'b1;
					state_nxt   = S_POP_WAIT;
				end
			end
			S_POP_WAIT: begin
				ctl.set_res = 1'b1;
				ctl.res_sel = rpq_pkg::RES_OK_RD;
				state_nxt   = S_DONE;
			end
			S_REM_START: begin
				if (sts.cnt_zero) begin
					ctl.set_res = 1'b1;
					ctl.res_sel = rpq_pkg::RES_NOT_FOUND;
					state_nxt   = S_DONE;
				end else begin
					ctl.idx_clr = 1'b1;
					state_nxt   = S_REM_RD;
				end
			end
			S_REM_RD: begin
				ctl.rd_en   = 1'b1;
				ctl.rd_sel  = rpq_pkg::RD_IDX;
				ctl.idx_inc = 1'b1;
				state_nxt   = S_REM_SCAN;
			end
			S_REM_SCAN: begin
				// first hit marks the gap; everything after it moves down one
				if (!sts.found && sts.id_match) begin
					ctl.set_found = 1'b1;
				end else if (sts.found) begin
					ctl.wr_en  = 1'b1;
					ctl.wa_sel = rpq_pkg::WA_PREV_M1;
					ctl.wd_sel = rpq_pkg::WD_RDATA;
				end
				if (sts.scan_last) begin
					state_nxt = S_REM_END;
				end else begin
					ctl.rd_en   = 1'b1;
					ctl.rd_sel  = rpq_pkg::RD_IDX;
					ctl.idx_inc = 1'b1;
				end
			end
			S_REM_END: begin
				ctl.set_res = 1'b1;
				if (sts.found) begin
					ctl.cnt_dec = 1'b1;
					ctl.res_sel = rpq_pkg::RES_OK_OP;
				end else begin
					ctl.res_sel = rpq_pkg::RES_NOT_FOUND;
				end
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (rsp_free) begin
					ctl.load_rsp = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> (state_q == S_DECODE))
		else $error("accepted word not decoded");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_rsp |-> (!rsp_valid_q || !rsp_stall))
		else $error("response register overwritten while held");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_rsp |=> (rsp_valid_q && state_q == S_IDLE))
		else $error("response not presented after load");
`endif

endmodule

`default_nettype wire

FILE: design/ready_priority_queue_core.sv
// ready_priority_queue_core: top level of the sorted-array scheduler ready queue.
// Depends on rpq_pkg, rpq_ctrl, rpq_dp (and rpq_ram below it).
//
//   channel | valid     | stall     | word                    | direction
//   --------+-----------+-----------+-------------------------+----------
//   request | cmd_valid | cmd_stall | cmd  (command, id, prio) | in
//   result  | rsp_valid | rsp_stall | rsp  (id, status, count) | out
//
// One request at a time. An enqueue walk shifts entries up one place each and ends with a compare
// when it stops early; a remove walk runs over every entry. Full enqueue, empty pop, empty remove
// and an unused code take no walk. The walks read the single-read-port entry RAM one entry per
// cycle. Reset clears the count, walk index and found flag; RAM contents are not cleared
// and need no pass. A new request is taken while a result is held in the output register;
// a finished operation waits until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module ready_priority_queue_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire rpq_pkg::cmd_word_t cmd,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output rpq_pkg::rsp_word_t      rsp
);

	rpq_pkg::dp_cmd_t ctl;
	rpq_pkg::dp_sts_t sts;

	rpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	rpq_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_word (cmd),
		.ctl      (ctl),
		.sts      (sts),
		.rsp_word (rsp)
	);

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// testbench: self-checking bench for the sorted-array ready queue (ready_priority_queue_core).
// Keeps its own copy of the queue, predicts each result word and checks it field by field.
// Depends on rpq_pkg and the design sources only.
`timescale 1ns / 1ps

module testbench;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cmd_valid = 1'b0;
	rpq_pkg::cmd_word_t cmd       = '0;
	logic               cmd_stall;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	rpq_pkg::rsp_word_t rsp;

	ready_priority_queue_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// shadow of the ready list, ascending priority, top entry at ready_len-1
	rpq_pkg::entry_t    ready_list [rpq_pkg::CAPACITY];
	int                 ready_len = 0;
	rpq_pkg::rsp_word_t pending_rsp [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_len      = 0;
	bit hold_req      = 1'b0;
	int hold_left     = 0;

	int errors    = 0;
	int words_in  = 0;
	int n_ok      = 0;
	int n_full    = 0;
	int n_empty   = 0;
	int n_missing = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#(64'd10_000_000);
		$display("FAILURE");
		$finish;
	end

	// updates the shadow list and returns the word the block should answer with
	function automatic rpq_pkg::rsp_word_t queue_update(input rpq_pkg::cmd_word_t w);
		rpq_pkg::rsp_word_t                r;
		logic [rpq_pkg::PRIORITY_BITS-1:0] p;
		int                                i;
		int                                pos;
		r   = '0;
		p   = rpq_pkg::PRIORITY_BITS'(w.priority_req);
		pos = -1;
		case (w.command)
			rpq_pkg::CMD_ENQUEUE: begin
				if (ready_len >= rpq_pkg::CAPACITY) begin
					r.status = rpq_pkg::ST_FULL;
				end else begin
					i = ready_len;
					while (i > 0 && ready_list[i-1].prio >= p) begin
						ready_list[i] = ready_list[i-1];
						i--;
					end
					ready_list[i].id   = w.task_id;
					ready_list[i].prio = p;
					ready_len++;
					r.result_id = w.task_id;
				end
			end
			rpq_pkg::CMD_POP: begin
				if (ready_len == 0) begin
					r.status = rpq_pkg::ST_EMPTY;
				end else begin
					ready_len--;
					r.result_id = ready_list[ready_len].id;
				end
			end
			rpq_pkg::CMD_REMOVE: begin
				for (i = 0; i < ready_len; i++) begin
					if (ready_list[i].id == w.task_id) begin
						pos = i;
						break;
					end
				end
				if (pos < 0) begin
					r.status = rpq_pkg::ST_NOT_FOUND;
				end else begin
					for (i = pos; i + 1 < ready_len; i++)
						ready_list[i] = ready_list[i+1];
					ready_len--;
					r.result_id = w.task_id;
				end
			end
			default: ;
		endcase
		r.entry_count = rpq_pkg::COUNT_OUT_W'(ready_len);
		return r;
	endfunction

	function automatic rpq_pkg::cmd_word_t mk_word(input logic [1:0] c, input int id,
		input int prio);
		rpq_pkg::cmd_word_t w;
		w.command      = c;
		w.task_id      = rpq_pkg::ID_W'(id);
		w.priority_req = rpq_pkg::PRIO_REQ_W'(prio);
		return w;
	endfunction

	function automatic bit id_queued(input logic [rpq_pkg::ID_W-1:0] id);
		int i;
		for (i = 0; i < ready_len; i++)
			if (ready_list[i].id == id)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic [rpq_pkg::ID_W-1:0] pick_free_id();
		logic [rpq_pkg::ID_W-1:0] c;
		int                       tries;
		c = rpq_pkg::ID_W'($urandom_range(31));
		for (tries = 0; tries < 64 && id_queued(c); tries++)
			c = rpq_pkg::ID_W'($urandom_range(31));
		return c;
	endfunction

	function automatic int pick_prio();
		if ($urandom_range(2) == 0)
			return $urandom_range(255);
		return $urandom_range(7);
	endfunction

	// one request word; the caller either sends again or drops valid in the same step
	task automatic send_word(input rpq_pkg::cmd_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= w;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		pending_rsp.push_back(queue_update(w));
		words_in++;
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_rsp(input rpq_pkg::rsp_word_t got);
		rpq_pkg::rsp_word_t want;
		if (pending_rsp.size() == 0) begin
			$display("%0t: unexpected result word: id %0d status %0d count %0d",
				$time, got.result_id, got.status, got.entry_count);
			errors++;
		end else begin
			want = pending_rsp.pop_front();
			if (got.result_id !== want.result_id) begin
				$display("%0t: result_id expected %0d, got %0d", $time,
					want.result_id, got.result_id);
				errors++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
				errors++;
			end
			if (got.entry_count !== want.entry_count) begin
				$display("%0t: entry_count expected %0d, got %0d", $time,
					want.entry_count, got.entry_count);
				errors++;
			end
		end
		case (got.status)
			rpq_pkg::ST_OK:    n_ok++;
			rpq_pkg::ST_FULL:  n_full++;
			rpq_pkg::ST_EMPTY: n_empty++;
			default:           n_missing++;
		endcase
	endtask

	// result side: checks accepted words, drives stall (random, or a long hold-off)
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			check_rsp(rsp);
		if (hold_req) begin
			hold_left = hold_len;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left--;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// empty-queue cases, ties in FIFO order, duplicate ids, unused code, field extremes
	task automatic test_directed();
		send_word(mk_word(rpq_pkg::CMD_POP, 0, 0));
		send_word(mk_word(rpq_pkg::CMD_REMOVE, 31, 255));
		send_word(mk_word(CMD_UNUSED, 31, 255));
		send_word(mk_word(rpq_pkg::CMD_ENQUEUE, 0, 0));
		send_word(mk_word(rpq_pkg::CMD_ENQUEUE, 31, 255));
		send_word(mk_word(rpq_pkg::CMD_ENQUEUE, 5, 100));
		send_word(mk_word(rpq_pkg::CMD_ENQUEUE, 6, 100));
		send_word(mk_word(rpq_pkg::CMD_ENQUEUE, 7, 100));
		send_word(mk_word(rpq_pkg::CMD_ENQUEUE, 5, 200));
		send_word(mk_word(rpq_pkg::CMD_ENQUEUE, 9, 128));
		// duplicate id: only the lower (prio 100) copy goes
		send_word(mk_word(rpq_pkg::CMD_REMOVE, 5, 0));
		send_word(mk_word(rpq_pkg::CMD_REMOVE, 20, 0));
		send_word(mk_word(CMD_UNUSED, 0, 0));
		repeat (7)
			send_word(mk_word(rpq_pkg::CMD_POP, 0, 0));
		wait_drained();
	endtask

	// fill to capacity, enqueue on full, remove at both ends, then empty it again
	task automatic test_full_queue();
		repeat (rpq_pkg::CAPACITY)
			send_word(mk_word(rpq_pkg::CMD_ENQUEUE, pick_free_id(), pick_prio()));
		send_word(mk_word(rpq_pkg::CMD_ENQUEUE, pick_free_id(), 255));
		send_word(mk_word(rpq_pkg::CMD_ENQUEUE, 0, 0));
		send_word(mk_word(rpq_pkg::CMD_REMOVE, ready_list[0].id, 0));
		send_word(mk_word(rpq_pkg::CMD_REMOVE, ready_list[ready_len-1].id, 0));
		send_word(mk_word(rpq_pkg::CMD_ENQUEUE, pick_free_id(), pick_prio()));
		send_word(mk_word(rpq_pkg::CMD_ENQUEUE, pick_free_id(), pick_prio()));
		send_word(mk_word(rpq_pkg::CMD_ENQUEUE, pick_free_id(), pick_prio()));
		while (ready_len > 0) begin
			if ($urandom_range(1))
				send_word(mk_word(rpq_pkg::CMD_POP, 0, 0));
			else
				send_word(mk_word(rpq_pkg::CMD_REMOVE,
					ready_list[$urandom_range(ready_len-1)].id, 0));
		end
		send_word(mk_word(rpq_pkg::CMD_POP, 0, 0));
		wait_drained();
	endtask

	// receiver holds off while requests keep coming, so the input stalls
	task automatic test_backpressure();
		hold_len = 300;
		hold_req = 1'b1;
		repeat (8)
			send_word(mk_word(rpq_pkg::CMD_ENQUEUE, pick_free_id(), pick_prio()));
		repeat (4)
			send_word(mk_word(rpq_pkg::CMD_POP, 0, 0));
		wait_drained();
	endtask

	task automatic test_random(input int n, input int s_pct, input int r_pct);
		rpq_pkg::cmd_word_t w;
		int                 fill_bias;
		int                 k;
		int                 r;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		fill_bias     = 70;
		for (k = 0; k < n; k++) begin
			// swing between filling and emptying so both ends are reached
			if (k % 48 == 0)
				fill_bias = $urandom_range(1) ? 72 : 28;
			r = $urandom_range(99);
			if (r < 3) begin
				w = mk_word(CMD_UNUSED, $urandom_range(31), $urandom_range(255));
			end else if (r < 3 + fill_bias) begin
				if ($urandom_range(9) == 0)
					w = mk_word(rpq_pkg::CMD_ENQUEUE, $urandom_range(31), pick_prio());
				else
					w = mk_word(rpq_pkg::CMD_ENQUEUE, pick_free_id(), pick_prio());
			end else if ($urandom_range(1)) begin
				w = mk_word(rpq_pkg::CMD_POP, $urandom_range(31), $urandom_range(255));
			end else if (ready_len > 0 && $urandom_range(6) != 0) begin
				w = mk_word(rpq_pkg::CMD_REMOVE, ready_list[$urandom_range(ready_len-1)].id,
					$urandom_range(255));
			end else begin
				w = mk_word(rpq_pkg::CMD_REMOVE, $urandom_range(31), $urandom_range(255));
			end
			send_word(w);
		end
		wait_drained();
	endtask

	initial begin
		send_idle_pct = 18;
		recv_idle_pct = 59;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_queue();
		test_backpressure();
		test_random(290, 18, 59);
		test_random(290, 59, 18);
		test_random(290, 0, 0);

		wait_drained();
		repeat (64)
			@(posedge clk);
		$display("Sent %0d request words: enqueue, pop, remove and unused code, queue empty to full.",
			words_in);
		$display("Results seen: %0d ok, %0d full, %0d empty, %0d not found; %0d mismatches.",
			n_ok, n_full, n_empty, n_missing, errors);
		if (errors == 0 && pending_rsp.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
